[rtl/core/fsg_pkg.sv]
// Shared types, constants and codes for the flex-sensor calibrate/scale/gesture block.
package fsg_pkg;

    localparam int FINGERS     = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int POS_W       = 12;
    localparam int JOY_W       = 10;
    localparam int SPAN_W      = SAMPLE_BITS + 1;
    localparam int FS_SHIFT    = 10;                      // full scale 1023 = 2^10 - 1
    localparam int NUM_W       = SAMPLE_BITS + FS_SHIFT;  // (raw - zero) * 1023
    localparam int DEN_W       = SAMPLE_BITS;             // positive span
    localparam int Q_W         = POS_W;                   // quotient bits before saturation
    localparam int DSH_W       = DEN_W + Q_W - 1;
    localparam int CNT_W       = $clog2(Q_W);
    localparam int IDX_W       = (FINGERS > 1) ? $clog2(FINGERS) : 1;

    localparam logic [1:0] CMD_NORMAL = 2'd0;
    localparam logic [1:0] CMD_ZERO   = 2'd1;
    localparam logic [1:0] CMD_SPAN   = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [SAMPLE_BITS-1:0] raw_thumb;
        logic [SAMPLE_BITS-1:0] raw_index;
        logic [SAMPLE_BITS-1:0] raw_middle;
        logic [SAMPLE_BITS-1:0] raw_ring;
        logic [SAMPLE_BITS-1:0] raw_pinky;
        logic [SAMPLE_BITS-1:0] raw_joy_x;
        logic [SAMPLE_BITS-1:0] raw_joy_y;
        logic                   pin_a;
        logic                   pin_b;
        logic                   pin_menu;
        logic                   pin_stick;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] pos_thumb;
        logic [POS_W-1:0] pos_index;
        logic [POS_W-1:0] pos_middle;
        logic [POS_W-1:0] pos_ring;
        logic [POS_W-1:0] pos_pinky;
        logic [JOY_W-1:0] joy_x;
        logic [JOY_W-1:0] joy_y;
        logic             grab;
        logic             pinch;
        logic             trigger;
        logic [3:0]       pressed;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic           ovf;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_START,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

[rtl/core/fsg_div.sv]
// Shared restoring divider: one quotient bit per cycle, flags quotients past Q_W bits.
module fsg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsg_pkg::t_div_req i_req,
    output fsg_pkg::t_div_rsp o_rsp
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic                       r_ovf, n_ovf;
    logic [fsg_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [fsg_pkg::NUM_W-1:0]  r_rem, n_rem;
    logic [fsg_pkg::DSH_W-1:0]  r_dsh, n_dsh;
    logic [fsg_pkg::Q_W-1:0]    r_quot, n_quot;
    logic                       ovf;
    logic                       ge;
    logic [fsg_pkg::DSH_W:0]    diff;

    // quotient >= 2^Q_W exactly when num >= den << Q_W
    assign ovf = ({{fsg_pkg::Q_W{1'b0}}, i_req.num} >=
                  {{fsg_pkg::NUM_W - fsg_pkg::DEN_W{1'b0}}, i_req.den, {fsg_pkg::Q_W{1'b0}}});
    assign diff = {{(fsg_pkg::DSH_W + 1 - fsg_pkg::NUM_W){1'b0}}, r_rem} - {1'b0, r_dsh};
    assign ge   = !diff[fsg_pkg::DSH_W];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = !ovf;
            n_done = ovf;
            n_ovf  = ovf;
            n_rem  = i_req.num;
            n_dsh  = {i_req.den, {(fsg_pkg::Q_W - 1){1'b0}}};
            n_cnt  = fsg_pkg::CNT_W'(fsg_pkg::Q_W - 1);
            n_quot = '0;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = diff[fsg_pkg::NUM_W-1:0];
            end
            n_quot = {r_quot[fsg_pkg::Q_W-2:0], ge};
            n_dsh  = r_dsh >> 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_ovf  <= n_ovf;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quot = r_quot;

endmodule

[rtl/core/flex_sensor_calibrate_scale_gesture_core.sv]
// Top level: flex-sensor two-point calibration, scaling, joystick, buttons and gestures.
// Each finger either skips the division, stops on quotient overflow, or divides in the
// shared divider (12 quotient bits); then the output register is loaded. No new frame
// is taken while one is in progress; the next frame is taken once the result is
// registered, which waits while the output register is full and stalled.
// Reset (synchronous, active low): zero levels and spans clear to 0, position limit to 4095.
module flex_sensor_calibrate_scale_gesture_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input frames
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fsg_pkg::t_in                    i_in_data,
    // results
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fsg_pkg::t_out                   o_out_data,
    // position limit register write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fsg_pkg::POS_W-1:0]       i_cfg_data
);

    fsg_pkg::t_state                   r_state, n_state;
    fsg_pkg::t_in                      r_in, n_in;
    fsg_pkg::t_out                     r_out, n_out;
    logic                              r_out_valid, n_out_valid;
    logic [fsg_pkg::POS_W-1:0]         r_amax, n_amax;
    logic [fsg_pkg::IDX_W-1:0]         r_idx, n_idx;
    logic [fsg_pkg::NUM_W-1:0]         r_num, n_num;
    logic [fsg_pkg::SAMPLE_BITS-1:0]   r_zero [fsg_pkg::FINGERS];
    logic [fsg_pkg::SAMPLE_BITS-1:0]   n_zero [fsg_pkg::FINGERS];
    logic [fsg_pkg::SPAN_W-1:0]        r_span [fsg_pkg::FINGERS];
    logic [fsg_pkg::SPAN_W-1:0]        n_span [fsg_pkg::FINGERS];
    logic [fsg_pkg::POS_W-1:0]         r_pos  [fsg_pkg::FINGERS];
    logic [fsg_pkg::POS_W-1:0]         n_pos  [fsg_pkg::FINGERS];

    logic [fsg_pkg::SAMPLE_BITS-1:0]   in_raw [fsg_pkg::FINGERS];
    logic [fsg_pkg::SAMPLE_BITS-1:0]   cur_raw;
    logic [fsg_pkg::SAMPLE_BITS-1:0]   cur_zero;
    logic [fsg_pkg::SPAN_W-1:0]        cur_span;
    logic [fsg_pkg::SAMPLE_BITS-1:0]   diff;
    logic                              skip;
    logic                              last;
    logic                              in_xfer;
    logic [fsg_pkg::POS_W-1:0]         sat_pos;
    logic [fsg_pkg::POS_W-2:0]         half;
    logic [fsg_pkg::POS_W+1:0]         sum4;
    logic [fsg_pkg::POS_W:0]           sum2;
    fsg_pkg::t_div_req                 div_req;
    fsg_pkg::t_div_rsp                 div_rsp;

    fsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // finger samples of the new transfer and of the held frame
    assign in_raw = '{i_in_data.raw_thumb, i_in_data.raw_index, i_in_data.raw_middle,
                      i_in_data.raw_ring, i_in_data.raw_pinky};

    always_comb begin
        case (r_idx)
            3'd0:    cur_raw = r_in.raw_thumb;
            3'd1:    cur_raw = r_in.raw_index;
            3'd2:    cur_raw = r_in.raw_middle;
            3'd3:    cur_raw = r_in.raw_ring;
            default: cur_raw = r_in.raw_pinky;
        endcase
    end

    assign cur_zero = r_zero[r_idx];
    assign cur_span = r_span[r_idx];
    assign diff     = cur_raw - cur_zero;
    // no division when the sample is not above zero or the span is not positive
    assign skip     = (cur_raw <= cur_zero) || cur_span[fsg_pkg::SPAN_W-1] || (cur_span == '0);
    assign last     = (r_idx == fsg_pkg::IDX_W'(fsg_pkg::FINGERS - 1));

    // quotient saturated at the position limit; divider overflow already exceeds any limit
    assign sat_pos = (div_rsp.ovf || (div_rsp.quot > r_amax)) ? r_amax : div_rsp.quot;

    // gesture sums over the finished positions
    assign half = r_amax[fsg_pkg::POS_W-1:1];
    assign sum4 = {2'b00, r_pos[1]} + {2'b00, r_pos[2]} + {2'b00, r_pos[3]} + {2'b00, r_pos[4]};
    assign sum2 = {1'b0, r_pos[0]} + {1'b0, r_pos[1]};

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != fsg_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_amax      = r_amax;
        n_idx       = r_idx;
        n_num       = r_num;
        n_zero      = r_zero;
        n_span      = r_span;
        n_pos       = r_pos;
        div_req     = '0;

        if (i_cfg_valid) begin
            n_amax = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fsg_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_in  = i_in_data;
                    n_idx = '0;
                    // captures land first so this frame already scales with them
                    for (int f = 0; f < fsg_pkg::FINGERS; f++) begin
                        if (i_in_data.cmd == fsg_pkg::CMD_ZERO) begin
                            n_zero[f] = in_raw[f];
                        end else if (i_in_data.cmd == fsg_pkg::CMD_SPAN) begin
                            n_span[f] = {1'b0, in_raw[f]} - {1'b0, r_zero[f]};
                        end
                    end
                    n_state = fsg_pkg::ST_CALC;
                end
            end
            fsg_pkg::ST_CALC: begin
                // diff * 1023 as (diff << 10) - diff
                n_num = {diff, {fsg_pkg::FS_SHIFT{1'b0}}} -
                        {{fsg_pkg::FS_SHIFT{1'b0}}, diff};
                if (skip) begin
                    n_pos[r_idx] = '0;
                    if (last) begin
                        n_state = fsg_pkg::ST_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_state = fsg_pkg::ST_START;
                end
            end
            fsg_pkg::ST_START: begin
                div_req.start = 1'b1;
                div_req.num   = r_num;
                div_req.den   = cur_span[fsg_pkg::DEN_W-1:0];
                n_state       = fsg_pkg::ST_WAIT;
            end
            fsg_pkg::ST_WAIT: begin
                if (div_rsp.done) begin
                    n_pos[r_idx] = sat_pos;
                    if (last) begin
                        n_state = fsg_pkg::ST_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = fsg_pkg::ST_CALC;
                    end
                end
            end
            fsg_pkg::ST_DONE: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_out.pos_thumb  = r_pos[0];
                    n_out.pos_index  = r_pos[1];
                    n_out.pos_middle = r_pos[2];
                    n_out.pos_ring   = r_pos[3];
                    n_out.pos_pinky  = r_pos[4];
                    n_out.joy_x      = r_in.raw_joy_x[fsg_pkg::SAMPLE_BITS-1:2];
                    n_out.joy_y      = r_in.raw_joy_y[fsg_pkg::SAMPLE_BITS-1:2];
                    n_out.grab       = (sum4[fsg_pkg::POS_W+1:2] > {1'b0, half});
                    n_out.pinch      = (sum2[fsg_pkg::POS_W:1] > {1'b0, half});
                    n_out.trigger    = (r_pos[1] > {1'b0, half});
                    n_out.pressed    = ~{r_in.pin_stick, r_in.pin_menu, r_in.pin_b, r_in.pin_a};
                    n_out_valid      = 1'b1;
                    n_state          = fsg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_amax      <= {fsg_pkg::POS_W{1'b1}};
            r_idx       <= '0;
            for (int f = 0; f < fsg_pkg::FINGERS; f++) begin
                r_zero[f] <= '0;
                r_span[f] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_amax      <= n_amax;
            r_idx       <= n_idx;
            r_zero      <= n_zero;
            r_span      <= n_span;
        end
        r_in  <= n_in;
        r_out <= n_out;
        r_num <= n_num;
        r_pos <= n_pos;
    end

endmodule

[sim/flex_sensor_calibrate_scale_gesture_core_test.sv]
// Self-checking testbench for the flex-sensor calibrate/scale/gesture core.
module flex_sensor_calibrate_scale_gesture_core_test;
    import fsg_pkg::*;

    localparam int         HALF_PERIOD  = 5;
    localparam int         IDLE_LIMIT   = 4000;   // cycles with no transfer on any channel
    localparam int         HOLD_CYCLES  = 300;    // long output hold-off
    localparam int         DRAIN_CYCLES = 100;    // settle time after the last expected result
    localparam int         FULL_SCALE   = 1023;
    localparam int         MAX_SAMPLE   = (1 << SAMPLE_BITS) - 1;
    localparam logic [1:0] CMD_SPARE    = 2'd3;   // unused code, behaves as a normal frame

    // ------------------------------------------------------------------
    // Clock, reset and DUT-facing signals. Everything driven by the bench
    // starts at a known value.
    // ------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [POS_W-1:0] cfg_data  = '0;
    logic             in_stall;
    logic             out_valid;
    t_out             out_data;
    logic             cfg_ready;

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    flex_sensor_calibrate_scale_gesture_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the calibration and the limit.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0]   zero_lvl [FINGERS];
    logic signed [SPAN_W-1:0] span_lvl [FINGERS];
    logic [POS_W-1:0]         amax_lvl;

    t_out scaled_frame_q [$];   // predicted results, oldest first

    int   err_cnt       = 0;
    int   frames_sent   = 0;
    int   results_seen  = 0;
    int   settings_cnt  = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   idle_cycles   = 0;
    logic hold_on       = 1'b0;
    event hold_ev;

    function automatic logic [SAMPLE_BITS-1:0] finger_raw(t_in f, int i);
        case (i)
            0:       return f.raw_thumb;
            1:       return f.raw_index;
            2:       return f.raw_middle;
            3:       return f.raw_ring;
            default: return f.raw_pinky;
        endcase
    endfunction

    function automatic t_in set_finger(t_in f, int i, logic [SAMPLE_BITS-1:0] v);
        case (i)
            0:       f.raw_thumb  = v;
            1:       f.raw_index  = v;
            2:       f.raw_middle = v;
            3:       f.raw_ring   = v;
            default: f.raw_pinky  = v;
        endcase
        return f;
    endfunction

    // floor((raw - zero) * 1023 / span), 0 below zero or for a non-positive span,
    // then clamped at the limit
    function automatic logic [POS_W-1:0] scale_finger(logic [SAMPLE_BITS-1:0] raw, int i);
        int num;
        int den;
        int q;
        num = int'(raw) - int'(zero_lvl[i]);
        den = int'(span_lvl[i]);
        if (num <= 0 || den <= 0) return '0;
        q = num * FULL_SCALE / den;
        if (q > int'(amax_lvl)) q = int'(amax_lvl);
        return POS_W'(q);
    endfunction

    // Captures land before scaling, so a capture frame already sees its own values.
    function automatic t_out calibrate_and_scale(t_in f);
        t_out                   r;
        int                     pos [FINGERS];
        int                     half;
        logic [SAMPLE_BITS-1:0] raw;
        half = int'(amax_lvl) / 2;
        for (int i = 0; i < FINGERS; i++) begin
            raw = finger_raw(f, i);
            if (f.cmd == CMD_ZERO) begin
                zero_lvl[i] = raw;
            end else if (f.cmd == CMD_SPAN) begin
                span_lvl[i] = SPAN_W'(int'(raw) - int'(zero_lvl[i]));
            end
            pos[i] = int'(scale_finger(raw, i));
        end
        r.pos_thumb  = POS_W'(pos[0]);
        r.pos_index  = POS_W'(pos[1]);
        r.pos_middle = POS_W'(pos[2]);
        r.pos_ring   = POS_W'(pos[3]);
        r.pos_pinky  = POS_W'(pos[4]);
        r.joy_x      = f.raw_joy_x[SAMPLE_BITS-1:2];
        r.joy_y      = f.raw_joy_y[SAMPLE_BITS-1:2];
        r.grab       = ((pos[1] + pos[2] + pos[3] + pos[4]) / 4) > half;
        r.pinch      = ((pos[0] + pos[1]) / 2) > half;
        r.trigger    = pos[1] > half;
        r.pressed    = {~f.pin_stick, ~f.pin_menu, ~f.pin_b, ~f.pin_a};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic t_in flat_frame(logic [1:0] c, logic [SAMPLE_BITS-1:0] raw,
                                       logic [SAMPLE_BITS-1:0] joy, logic [3:0] pins);
        t_in f;
        f.cmd = c;
        for (int i = 0; i < FINGERS; i++) f = set_finger(f, i, raw);
        f.raw_joy_x = joy;
        f.raw_joy_y = ~joy;
        {f.pin_stick, f.pin_menu, f.pin_b, f.pin_a} = pins;
        return f;
    endfunction

    // sample around the calibrated band of one finger, now and then anywhere
    function automatic int near_band(int i);
        int lo;
        int hi;
        if ($urandom_range(7, 0) == 0) return int'($urandom_range(MAX_SAMPLE, 0));
        lo = int'(zero_lvl[i]) - 64;
        hi = int'(zero_lvl[i]) + ((span_lvl[i] > 0) ? int'(span_lvl[i]) : 256) + 64;
        if (lo < 0) lo = 0;
        if (hi > MAX_SAMPLE) hi = MAX_SAMPLE;
        return int'($urandom_range(hi, lo));
    endfunction

    // wild frames keep fully random samples; others are shaped by the command
    function automatic t_in rand_frame(logic [1:0] c, bit wild);
        logic [95:0] bits;
        t_in         f;
        int          z;
        int          r;
        int          sel;
        bits  = {$urandom, $urandom, $urandom};
        f     = bits[$bits(t_in)-1:0];
        f.cmd = c;
        if (!wild) begin
            for (int i = 0; i < FINGERS; i++) begin
                z   = int'(zero_lvl[i]);
                sel = $urandom_range(9, 0);
                if (c == CMD_ZERO) begin
                    r = (sel == 0) ? int'($urandom_range(MAX_SAMPLE, 0))
                                   : int'($urandom_range(2500, 0));
                end else if (c == CMD_SPAN) begin
                    if (sel < 2 || z == MAX_SAMPLE) begin
                        r = int'($urandom_range(z, 0));      // span at or below zero
                    end else if (sel < 4) begin
                        r = z + int'($urandom_range((MAX_SAMPLE - z < 16) ? MAX_SAMPLE - z : 16, 1));
                    end else begin
                        r = z + int'($urandom_range(MAX_SAMPLE - z, 1));
                    end
                end else begin
                    r = near_band(i);
                end
                f = set_finger(f, i, SAMPLE_BITS'(r));
            end
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers. Valid is left high after a transfer; the next call
    // either lowers it for an idle gap or presents the next frame, so it
    // gets one assignment per time step.
    // ------------------------------------------------------------------
    task automatic send_frame(t_in f);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        scaled_frame_q.push_back(calibrate_and_scale(f));
        frames_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (scaled_frame_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // limit is changed only with the block idle
    task automatic write_limit(logic [POS_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        amax_lvl = v;
        settings_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, plus a long hold-off counted in its own process
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= hold_on || ($urandom_range(99, 0) < stall_pct);
    end

    initial forever begin
        @(hold_ev);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [POS_W-1:0] e, logic [POS_W-1:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            err_cnt++;
        end
    endfunction

    function automatic void check_result(t_out e, t_out a);
        check_field("pos_thumb",  e.pos_thumb,  a.pos_thumb);
        check_field("pos_index",  e.pos_index,  a.pos_index);
        check_field("pos_middle", e.pos_middle, a.pos_middle);
        check_field("pos_ring",   e.pos_ring,   a.pos_ring);
        check_field("pos_pinky",  e.pos_pinky,  a.pos_pinky);
        check_field("joy_x",      POS_W'(e.joy_x),   POS_W'(a.joy_x));
        check_field("joy_y",      POS_W'(e.joy_y),   POS_W'(a.joy_y));
        check_field("grab",       POS_W'(e.grab),    POS_W'(a.grab));
        check_field("pinch",      POS_W'(e.pinch),   POS_W'(a.pinch));
        check_field("trigger",    POS_W'(e.trigger), POS_W'(a.trigger));
        check_field("pressed",    POS_W'(e.pressed), POS_W'(a.pressed));
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (scaled_frame_q.size() == 0) begin
                $display("%0t: result with no frame pending, expected none, actual %p",
                         $time, out_data);
                err_cnt++;
            end else begin
                check_result(scaled_frame_q.pop_front(), out_data);
                results_seen++;
            end
        end
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, scaled_frame_q.size());
            $display("flex_sensor_calibrate_scale_gesture_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // spans are 0 after reset: every position 0; joystick and pin extremes
    task automatic test_after_reset();
        send_frame(flat_frame(CMD_NORMAL, 12'hFFF, 12'hFFF, 4'h0));
        send_frame(flat_frame(CMD_NORMAL, 12'h000, 12'h000, 4'hF));
        send_frame(flat_frame(CMD_SPARE,  12'h800, 12'h003, 4'h5));
    endtask

    // capture timing, sample at/below zero, non-positive span, full and tiny spans
    task automatic test_capture();
        t_in f;
        send_frame(flat_frame(CMD_ZERO,   12'h000, 12'h7FF, 4'hA));
        send_frame(flat_frame(CMD_SPAN,   12'hFFF, 12'h800, 4'h0));  // same frame uses span
        f = flat_frame(CMD_NORMAL, 12'h800, 12'h123, 4'hF);
        f = set_finger(f, 0, 12'h001);
        f = set_finger(f, 4, 12'hFFE);
        send_frame(f);
        send_frame(flat_frame(CMD_NORMAL, 12'h000, 12'hFFC, 4'h3));  // raw equal to zero
        send_frame(flat_frame(CMD_ZERO,   12'd100, 12'h400, 4'hC));
        send_frame(flat_frame(CMD_SPAN,   12'd50,  12'h400, 4'hC));  // negative span
        send_frame(flat_frame(CMD_SPARE,  12'd4000, 12'h400, 4'h6));
        send_frame(flat_frame(CMD_ZERO,   12'hFFF, 12'h001, 4'h9));
        send_frame(flat_frame(CMD_SPAN,   12'hFFF, 12'h001, 4'h9));  // zero span
        send_frame(flat_frame(CMD_ZERO,   12'h000, 12'hFFF, 4'h0));
        send_frame(flat_frame(CMD_SPAN,   12'h001, 12'hFFF, 4'hF));  // span of one
        send_frame(flat_frame(CMD_NORMAL, 12'hFFF, 12'h555, 4'h1));  // saturates
    endtask

    // limit extremes: 0 forces all zeros and flags off; 1 makes threshold 0
    task automatic test_limit_extremes();
        write_limit(12'd0);
        send_frame(flat_frame(CMD_NORMAL, 12'hFFF, 12'hAAA, 4'h2));
        write_limit(12'd1);
        send_frame(flat_frame(CMD_NORMAL, 12'hFFF, 12'hAAA, 4'h4));
        send_frame(flat_frame(CMD_NORMAL, 12'h000, 12'h555, 4'h8));
        write_limit(12'd2047);
        send_frame(flat_frame(CMD_NORMAL, 12'hFFF, 12'h0F0, 4'hE));
        send_frame(flat_frame(CMD_NORMAL, 12'd2, 12'hF0F, 4'h7));
        write_limit(12'hFFF);
    endtask

    // Random stream: mostly calibration sequences and normal frames around the
    // calibrated band, the rest noise with any command and shaped or fully random samples.
    task automatic test_stream_phase(int send_pct, int stall_p, logic [POS_W-1:0] limit, int n);
        int left;
        int pick;
        int run;
        write_limit(limit);
        send_idle_pct = send_pct;
        stall_pct     = stall_p;
        left          = n;
        while (left > 0) begin
            pick = $urandom_range(99, 0);
            if (pick < 12) begin
                send_frame(rand_frame(CMD_ZERO, 1'b0));
                run = $urandom_range(3, 0);
                repeat (run) send_frame(rand_frame(CMD_NORMAL, 1'b0));
                send_frame(rand_frame(CMD_SPAN, 1'b0));
                left -= run + 2;
            end else if (pick < 22) begin
                send_frame(rand_frame(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0))));
                left--;
            end else begin
                send_frame(rand_frame(CMD_NORMAL, 1'b0));
                left--;
            end
        end
    endtask

    // output held off for a long stretch while frames keep coming: the core
    // fills and must stall its input without losing or reordering anything
    task automatic test_backpressure();
        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_ev;
        repeat (12) send_frame(rand_frame(CMD_NORMAL, 1'b0));
    endtask

    initial begin : main
        for (int i = 0; i < FINGERS; i++) begin
            zero_lvl[i] = '0;
            span_lvl[i] = '0;
        end
        amax_lvl = 12'hFFF;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_capture();
        test_limit_extremes();
        test_stream_phase(0,  0,  12'hFFF, 340);
        test_stream_phase(73, 0,  12'($urandom_range(MAX_SAMPLE, 1)), 340);
        test_stream_phase(0,  73, 12'($urandom_range(600, 1)), 340);
        test_stream_phase(31, 31, 12'($urandom_range(MAX_SAMPLE, 2048)), 340);
        test_backpressure();
        wait_drained();

        $display("run covered %0d frames and %0d checked results under %0d limit settings,",
                 frames_sent, results_seen, settings_cnt);
        $display("with captures, out-of-band samples, sender gaps, stalls and a long hold-off");
        if (err_cnt == 0) begin
            $display("flex_sensor_calibrate_scale_gesture_core test passed");
        end else begin
            $display("flex_sensor_calibrate_scale_gesture_core test failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/fsg_pkg.sv
rtl/core/fsg_div.sv
rtl/core/flex_sensor_calibrate_scale_gesture_core.sv
sim/flex_sensor_calibrate_scale_gesture_core_test.sv
